/* design/lgsg_pkg.sv */
// Package with the shared types, codes and jump-ahead functions of the Gold sequence generator.
package lgsg_pkg;

	localparam int LFSR_W = 31;
	localparam int LEN_W  = 16;
	localparam int OUT_W  = 32;
	localparam int CNT_W  = 6;

	typedef logic [LFSR_W-1:0] lgsg_reg_t;
	typedef lgsg_reg_t [LFSR_W-1:0] lgsg_mat_t;

	typedef struct packed {
		lgsg_reg_t x1;
		lgsg_reg_t x2;
	} lgsg_lfsr_t;

	typedef enum logic {
		ACT_START = 1'b0,
		ACT_GEN   = 1'b1
	} lgsg_action_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_START = 2'd1,
		ST_EMPTY = 2'd2
	} lgsg_status_t;

	function automatic lgsg_reg_t lgsg_step_x1(lgsg_reg_t a);
		return {a[0] ^ a[3], a[LFSR_W-1:1]};
	endfunction

	function automatic lgsg_reg_t lgsg_step_x2(lgsg_reg_t b);
		return {b[0] ^ b[1] ^ b[2] ^ b[3], b[LFSR_W-1:1]};
	endfunction

	// Contents of x1 after the given number of steps from the value one.
	function automatic lgsg_reg_t lgsg_jump_x1(int steps);
		lgsg_reg_t s;
		s = lgsg_reg_t'(1);
		for (int n = 0; n < steps; n++)
			s = lgsg_step_x1(s);
		return s;
	endfunction

	// Row r gives the seed bits whose XOR forms bit r of x2 after the given steps.
	function automatic lgsg_mat_t lgsg_jump_matrix(int steps);
		lgsg_mat_t cols;
		lgsg_mat_t m;
		for (int j = 0; j < LFSR_W; j++)
			cols[j] = lgsg_reg_t'(1) << j;
		for (int n = 0; n < steps; n++)
			for (int j = 0; j < LFSR_W; j++)
				cols[j] = lgsg_step_x2(cols[j]);
		for (int r = 0; r < LFSR_W; r++)
			for (int j = 0; j < LFSR_W; j++)
				m[r][j] = cols[j][r];
		return m;
	endfunction

endpackage

/* design/lgsg_word.sv */
// Word builder: forms the next sequence bits and the advanced shift register windows.
module lgsg_word import lgsg_pkg::*; #(
	parameter int WS = 32
) (
	input  lgsg_lfsr_t       cur,
	input  logic [CNT_W-1:0] count,
	output logic [OUT_W-1:0] word,
	output lgsg_lfsr_t       nxt
);

	localparam int EXT = LFSR_W + WS;

	logic [EXT-1:0] x1e;
	logic [EXT-1:0] x2e;
	logic [EXT-1:0] x1sh;
	logic [EXT-1:0] x2sh;

	always_comb begin
		x1e = '0;
		x2e = '0;
		x1e[LFSR_W-1:0] = cur.x1;
		x2e[LFSR_W-1:0] = cur.x2;
		for (int k = LFSR_W; k < EXT; k++) begin
			x1e[k] = x1e[k-28] ^ x1e[k-31];
			x2e[k] = x2e[k-28] ^ x2e[k-29] ^ x2e[k-30] ^ x2e[k-31];
		end
	end

	always_comb begin
		word = '0;
		for (int i = 0; i < WS; i++)
			word[i] = (CNT_W'(i) < count) & (x1e[i] ^ x2e[i]);
	end

	assign x1sh   = x1e >> count;
	assign x2sh   = x2e >> count;
	assign nxt.x1 = x1sh[LFSR_W-1:0];
	assign nxt.x2 = x2sh[LFSR_W-1:0];

endmodule

/* design/lte_gold_sequence_generator_top.sv */
// Top level of the length-31 Gold sequence generator for scrambling.
// An accepted item is held in the input stage, and its result is then registered in the output stage.
// Throughput: one item per cycle, start and generate alike, while rsp_stall does not hold a pending result.
// The warm-up jump is a fixed XOR network, so a start does not step through the warm-up.
// Reset clears both shift registers and the remaining count to zero.
// A generate item before any start therefore reports that no bits are left.
module lte_gold_sequence_generator_top import lgsg_pkg::*; #(
	parameter int WARMUP_STEPS = 1600,
	parameter int WORD_BITS    = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	input  logic              action,
	input  logic [LFSR_W-1:0] seed,
	input  logic [LEN_W-1:0]  seq_length,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output logic [OUT_W-1:0]  bits,
	output logic [CNT_W-1:0]  valid_bits,
	output logic              last,
	output logic [1:0]        status
);

	localparam int WS = (WORD_BITS > OUT_W) ? OUT_W : WORD_BITS;
	localparam logic [LEN_W-1:0] WS_LEN = LEN_W'(WS);
	localparam lgsg_reg_t X1_JUMP = lgsg_jump_x1(WARMUP_STEPS);
	localparam lgsg_mat_t X2_JUMP = lgsg_jump_matrix(WARMUP_STEPS);

	logic              valid_s1;
	lgsg_action_t      action_s1;
	logic [LFSR_W-1:0] seed_s1;
	logic [LEN_W-1:0]  len_s1;

	lgsg_lfsr_t        lfsr_q;
	logic [LEN_W-1:0]  remaining_q;

	logic [OUT_W-1:0]  bits_q;
	logic [CNT_W-1:0]  valid_bits_q;
	logic              last_q;
	lgsg_status_t      status_q;

	logic              out_free;
	logic              adv;
	logic [CNT_W-1:0]  count;
	logic [LEN_W-1:0]  rem_next;
	logic [OUT_W-1:0]  word;
	lgsg_lfsr_t        lfsr_gen;
	lgsg_reg_t         x2_start;

	assign out_free  = !rsp_valid || !rsp_stall;
	assign adv       = valid_s1 && out_free;
	assign req_stall = valid_s1 && !out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!req_stall) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && !req_stall) begin
			action_s1 <= lgsg_action_t'(action);
			seed_s1   <= seed;
			len_s1    <= seq_length;
		end
	end

	always_comb begin
		for (int r = 0; r < LFSR_W; r++)
			x2_start[r] = ^(X2_JUMP[r] & seed_s1);
	end

	assign count    = (remaining_q < WS_LEN) ? CNT_W'(remaining_q) : CNT_W'(WS);
	assign rem_next = remaining_q - LEN_W'(count);

	lgsg_word #(.WS(WS)) u_word (
		.cur   (lfsr_q),
		.count (count),
		.word  (word),
		.nxt   (lfsr_gen)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lfsr_q      <= '0;
			remaining_q <= '0;
			rsp_valid   <= 1'b0;
		end else begin
			if (adv) begin
				if (action_s1 == ACT_START) begin
					lfsr_q.x1   <= X1_JUMP;
					lfsr_q.x2   <= x2_start;
					remaining_q <= len_s1;
				end else if (remaining_q != '0) begin
					lfsr_q      <= lfsr_gen;
					remaining_q <= rem_next;
				end
			end
			if (out_free) begin
				rsp_valid <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (action_s1 == ACT_START) begin
				bits_q       <= '0;
				valid_bits_q <= '0;
				last_q       <= 1'b0;
				status_q     <= ST_START;
			end else if (remaining_q == '0) begin
				bits_q       <= '0;
				valid_bits_q <= '0;
				last_q       <= 1'b0;
				status_q     <= ST_EMPTY;
			end else begin
				bits_q       <= word;
				valid_bits_q <= count;
				last_q       <= (count != '0) && (rem_next == '0);
				status_q     <= ST_OK;
			end
		end
	end

	assign bits       = bits_q;
	assign valid_bits = valid_bits_q;
	assign last       = last_q;
	assign status     = status_q;

	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> ((bits >> valid_bits) == '0))
		else $error("result carries bits beyond its valid count");

	a_last_has_bits: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && last |-> (valid_bits != '0) && (status_q == ST_OK))
		else $error("last flag on a result without sequence bits");

	a_start_clean: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (status_q != ST_OK) |-> (valid_bits == '0) && !last)
		else $error("start or empty result reports sequence bits");

	a_hold_state: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(remaining_q) && $stable(lfsr_q))
		else $error("generator state changed without an item");

	a_back_pressure: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && rsp_valid && rsp_stall |-> req_stall)
		else $error("input taken while the stage could not drain");

endmodule

/* bench/lte_gold_sequence_generator_top_test.sv */
// Self-checking testbench for the Gold sequence generator: directed table, random sequences.
module lte_gold_sequence_generator_top_test;
	import lgsg_pkg::*;

	localparam int WARMUP    = 1600;
	localparam int WORD      = 32;
	localparam int GOLD_WORD = (WORD > OUT_W) ? OUT_W : WORD;
	localparam int RAND_ITEMS = 600;

	typedef struct packed {
		logic [OUT_W-1:0] bits;
		logic [CNT_W-1:0] count;
		logic             last;
		lgsg_status_t     status;
	} gold_word_t;

	typedef struct {
		lgsg_action_t   act;
		lgsg_reg_t      seed;
		logic [LEN_W-1:0] len;
		bit             pinned;
		gold_word_t     want;
	} dir_row_t;

	localparam gold_word_t EMPTY_WORD = '{32'd0, 6'd0, 1'b0, ST_EMPTY};
	localparam gold_word_t ACK_WORD   = '{32'd0, 6'd0, 1'b0, ST_START};
	localparam gold_word_t ANY_WORD   = '{32'd0, 6'd0, 1'b0, ST_OK};
	localparam int N_DIR = 26;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             req_valid = 1'b0;
	logic             req_stall;
	logic             action = ACT_START;
	logic [LFSR_W-1:0] seed = '0;
	logic [LEN_W-1:0] seq_length = '0;
	logic             rsp_valid;
	logic             rsp_stall = 1'b0;
	logic [OUT_W-1:0] bits;
	logic [CNT_W-1:0] valid_bits;
	logic             last;
	logic [1:0]       status;

	lgsg_reg_t        gold_x1 = '0;
	lgsg_reg_t        gold_x2 = '0;
	logic [LEN_W-1:0] gold_left = '0;
	gold_word_t       words_due[$];
	int               mismatch_count = 0;
	int               idle_pct = 0;
	int               stall_pct = 0;

	dir_row_t dir_rows [N_DIR] = '{
		'{ACT_GEN,   31'h0000_0000, 16'd0,     1'b1, EMPTY_WORD},
		'{ACT_START, 31'h0000_0000, 16'd0,     1'b1, ACK_WORD},
		'{ACT_GEN,   31'h0000_0000, 16'd0,     1'b1, EMPTY_WORD},
		'{ACT_START, 31'h7FFF_FFFF, 16'hFFFF,  1'b1, ACK_WORD},
		'{ACT_GEN,   31'h0000_0000, 16'd0,     1'b0, ANY_WORD},
		'{ACT_GEN,   31'h7FFF_FFFF, 16'hFFFF,  1'b0, ANY_WORD},
		'{ACT_START, 31'h0000_0000, 16'd64,    1'b1, ACK_WORD},
		'{ACT_GEN,   31'h0000_0000, 16'd0,     1'b0, ANY_WORD},
		'{ACT_GEN,   31'h0000_0000, 16'd0,     1'b0, ANY_WORD},
		'{ACT_GEN,   31'h0000_0000, 16'd0,     1'b1, EMPTY_WORD},
		'{ACT_START, 31'h0000_0001, 16'd1,     1'b1, ACK_WORD},
		'{ACT_GEN,   31'h0000_0000, 16'd0,     1'b0, ANY_WORD},
		'{ACT_GEN,   31'h0000_0000, 16'd0,     1'b1, EMPTY_WORD},
		'{ACT_START, 31'h2AAA_AAAA, 16'd32,    1'b1, ACK_WORD},
		'{ACT_GEN,   31'h0000_0000, 16'd0,     1'b0, ANY_WORD},
		'{ACT_GEN,   31'h0000_0000, 16'd0,     1'b1, EMPTY_WORD},
		'{ACT_START, 31'h5555_5555, 16'd33,    1'b1, ACK_WORD},
		'{ACT_GEN,   31'h0000_0000, 16'd0,     1'b0, ANY_WORD},
		'{ACT_GEN,   31'h0000_0000, 16'd0,     1'b0, ANY_WORD},
		'{ACT_GEN,   31'h0000_0000, 16'd0,     1'b1, EMPTY_WORD},
		'{ACT_START, 31'h1234_5678, 16'd31,    1'b1, ACK_WORD},
		'{ACT_GEN,   31'h0000_0000, 16'd0,     1'b0, ANY_WORD},
		'{ACT_START, 31'h4000_0000, 16'h8000,  1'b1, ACK_WORD},
		'{ACT_GEN,   31'h0000_0000, 16'd0,     1'b0, ANY_WORD},
		'{ACT_START, 31'h0F0F_0F0F, 16'd5,     1'b1, ACK_WORD},
		'{ACT_GEN,   31'h0000_0000, 16'd0,     1'b0, ANY_WORD}
	};

	lte_gold_sequence_generator_top #(
		.WARMUP_STEPS(WARMUP),
		.WORD_BITS(WORD)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.action(action),
		.seed(seed),
		.seq_length(seq_length),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.bits(bits),
		.valid_bits(valid_bits),
		.last(last),
		.status(status)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic void shift_gold();
		logic fb1;
		logic fb2;
		fb1 = gold_x1[0] ^ gold_x1[3];
		fb2 = ^gold_x2[3:0];
		gold_x1 = (gold_x1 >> 1) | (lgsg_reg_t'(fb1) << (LFSR_W - 1));
		gold_x2 = (gold_x2 >> 1) | (lgsg_reg_t'(fb2) << (LFSR_W - 1));
	endfunction

	function automatic gold_word_t predict_word(lgsg_action_t act, lgsg_reg_t sd,
			logic [LEN_W-1:0] len);
		gold_word_t r;
		int n;
		r = '{32'd0, 6'd0, 1'b0, ST_OK};
		if (act == ACT_START) begin
			gold_x1 = lgsg_reg_t'(1);
			gold_x2 = sd;
			gold_left = len;
			for (int i = 0; i < WARMUP; i++)
				shift_gold();
			r.status = ST_START;
		end else if (gold_left == 0) begin
			r.status = ST_EMPTY;
		end else begin
			n = (int'(gold_left) < GOLD_WORD) ? int'(gold_left) : GOLD_WORD;
			for (int i = 0; i < n; i++) begin
				r.bits[i] = gold_x1[0] ^ gold_x2[0];
				shift_gold();
			end
			gold_left = gold_left - LEN_W'(n);
			r.count = CNT_W'(n);
			r.last = (n != 0) && (gold_left == 0);
		end
		return r;
	endfunction

	task automatic send_item(input lgsg_action_t act, input lgsg_reg_t sd,
			input logic [LEN_W-1:0] len, input bit pinned, input gold_word_t want);
		gold_word_t guess;
		while ($urandom_range(0, 99) < idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		action <= act;
		seed <= sd;
		seq_length <= len;
		do @(posedge clk); while (req_stall);
		guess = predict_word(act, sd, len);
		words_due.push_back(pinned ? want : guess);
	endtask

	always @(posedge clk) begin
		rsp_stall <= ($urandom_range(0, 99) < stall_pct);
	end

	always @(posedge clk) begin
		gold_word_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (words_due.size() == 0) begin
				$error("unexpected result: bits %h, status %0d", bits, status);
				mismatch_count++;
			end else begin
				want = words_due.pop_front();
				if (bits !== want.bits) begin
					$error("bits: expected %h, got %h", want.bits, bits);
					mismatch_count++;
				end
				if (valid_bits !== want.count) begin
					$error("valid_bits: expected %0d, got %0d", want.count, valid_bits);
					mismatch_count++;
				end
				if (last !== want.last) begin
					$error("last: expected %b, got %b", want.last, last);
					mismatch_count++;
				end
				if (status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, status);
					mismatch_count++;
				end
			end
		end
	end

	initial begin
		int nrand;
		int ngen;
		lgsg_reg_t sd;
		logic [LEN_W-1:0] len;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (int i = 0; i < N_DIR; i++)
			send_item(dir_rows[i].act, dir_rows[i].seed, dir_rows[i].len,
				dir_rows[i].pinned, dir_rows[i].want);
		nrand = 0;
		while (nrand < RAND_ITEMS) begin
			case (nrand / (RAND_ITEMS / 4))
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 87; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 87; end
				default: begin idle_pct = 36; stall_pct = 36; end
			endcase
			if ($urandom_range(0, 9) < 8) begin
				sd = lgsg_reg_t'($urandom);
				if ($urandom_range(0, 7) == 0)
					len = LEN_W'($urandom);
				else
					len = LEN_W'($urandom_range(0, 160));
				send_item(ACT_START, sd, len, 1'b0, ANY_WORD);
				ngen = (int'(len) + GOLD_WORD - 1) / GOLD_WORD + $urandom_range(0, 1);
				if (ngen > 20)
					ngen = 20;
				for (int g = 0; g < ngen; g++)
					send_item(ACT_GEN, lgsg_reg_t'($urandom), LEN_W'($urandom),
						1'b0, ANY_WORD);
				nrand += ngen + 1;
			end else begin
				send_item(lgsg_action_t'($urandom_range(0, 1)), lgsg_reg_t'($urandom),
					LEN_W'($urandom), 1'b0, ANY_WORD);
				nrand++;
			end
		end
		req_valid <= 1'b0;
		while (words_due.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatch_count == 0)
			$display("** lte_gold_sequence_generator_top: PASSED **");
		else
			$display("** lte_gold_sequence_generator_top: FAILED **");
		$finish;
	end

	initial begin
		#5000000;
		$display("** lte_gold_sequence_generator_top: FAILED **");
		$finish;
	end

endmodule
